// ===== hw/rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed widths, arithmetic constants and the hue sector type shared by the
// converter core.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Widths of the pixel words.
    localparam int HUE_WIDTH  = 15;
    localparam int CHAN_WIDTH = 8;

    // Full scale of a channel, saturation or brightness word.
    localparam int CHAN_MAX = 255;

    // Coarse hue steps of four degrees: per turn and per 60-degree sector.
    localparam int STEPS_TURN   = 90;
    localparam int STEPS_SECTOR = 15;
    localparam int SECTOR_DEG   = 60;

    // All three channel numerators are scaled so that they divide by 255 * 15.
    localparam int NUM_WIDTH   = 20;
    localparam int CHAN_DIVSR  = CHAN_MAX * STEPS_SECTOR;

    // Rounded-up reciprocal of the channel divisor. With numerators below
    // 2^20 and a divisor below 2^12, a shift of 32 gives exact quotients.
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_WIDTH = 21;
    localparam logic [RECIP_WIDTH-1:0] CHAN_RECIP =
        RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) / 64'(CHAN_DIVSR)) + 64'd1);

    // Pipeline stages from an accepted word to its result strobe.
    localparam int PIPE_DEPTH = 6;

    // The six 60-degree sectors of the hue circle.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

// ===== hw/rtl/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Accepted words run through a six-stage pipeline to their result strobe;
// one word is taken in every cycle while busy is low. The result is strobed
// for one cycle only, as the receiver cannot stall. busy is high only during
// the synchronous reset, which empties the pipeline, and the cycle after it.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [hsv2rgb_pkg::HUE_WIDTH-1:0]  i_hue,
    input  logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] i_saturation,
    input  logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] i_brightness,
    output logic                               o_strobe,
    output logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] o_red,
    output logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] o_green,
    output logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] o_blue
);

    localparam int CW = hsv2rgb_pkg::CHAN_WIDTH;
    localparam int NW = hsv2rgb_pkg::NUM_WIDTH;
    localparam int PD = hsv2rgb_pkg::PIPE_DEPTH;

    // Low hue bits below one four-degree step, and the coarse hue width.
    localparam int SH = HUE_FRAC_BITS + 2;
    localparam int HW = hsv2rgb_pkg::HUE_WIDTH - SH;

    // Rounded-up reciprocal of the steps per turn, exact for HW-bit values.
    localparam int S1 = HW + 7;
    localparam logic [S1-1:0] TURN_RECIP =
        S1'(((64'd1 << S1) / 64'(hsv2rgb_pkg::STEPS_TURN)) + 64'd1);

    // Remainder within a sector, its divisor and the full q/t denominator.
    localparam int RW        = SH + 4;
    localparam int SEC_DIV   = hsv2rgb_pkg::SECTOR_DEG << HUE_FRAC_BITS;
    localparam logic [RW-1:0]   SEC_SIZE = RW'(SEC_DIV);
    localparam logic [RW+7:0]   DEN      = (RW + 8)'(hsv2rgb_pkg::CHAN_MAX * SEC_DIV);
    localparam logic [hsv2rgb_pkg::HUE_WIDTH-1:0] HUE_SEC0_END =
        hsv2rgb_pkg::HUE_WIDTH'(SEC_DIV);

    // Pipeline control.
    logic          r_busy;
    logic [PD-1:0] r_vld;

    // Stage 1: coarse hue and its quotient by the steps per turn.
    logic [HW+S1-1:0] n_turn_prod;
    logic [HW-1:0]    r_h1;
    logic [HW-1:0]    r_k1;
    logic [SH-1:0]    r_lo1;
    logic [CW-1:0]    r_s1;
    logic [CW-1:0]    r_v1;

    // Stage 2: sector and remainder within the sector.
    logic [HW+6:0]           n_m_full;
    logic [6:0]              n_m;
    logic [6:0]              n_base;
    hsv2rgb_pkg::t_sector    n_sec;
    logic [3:0]              n_r15;
    hsv2rgb_pkg::t_sector    r_sec2;
    logic [RW-1:0]           r_rem2;
    logic [CW-1:0]           r_s2;
    logic [CW-1:0]           r_v2;

    // Stage 3: saturation products and the p numerator.
    logic [RW-1:0]           n_dr;
    logic [2*CW-1:0]         n_vs;
    hsv2rgb_pkg::t_sector    r_sec3;
    logic [RW+7:0]           r_xq3;
    logic [RW+7:0]           r_xt3;
    logic [NW-1:0]           r_pn3;
    logic [CW-1:0]           r_v3;

    // Stage 4: q and t numerators over the common divisor.
    logic [RW+15:0]          n_q_full;
    logic [RW+15:0]          n_t_full;
    hsv2rgb_pkg::t_sector    r_sec4;
    logic [NW-1:0]           r_qn4;
    logic [NW-1:0]           r_tn4;
    logic [NW-1:0]           r_pn4;
    logic [CW-1:0]           r_v4;

    // Stage 5: channel quotients.
    logic [NW+hsv2rgb_pkg::RECIP_WIDTH-1:0] n_p_prod;
    logic [NW+hsv2rgb_pkg::RECIP_WIDTH-1:0] n_q_prod;
    logic [NW+hsv2rgb_pkg::RECIP_WIDTH-1:0] n_t_prod;
    hsv2rgb_pkg::t_sector    r_sec5;
    logic [CW-1:0]           r_p5;
    logic [CW-1:0]           r_q5;
    logic [CW-1:0]           r_t5;
    logic [CW-1:0]           r_v5;

    // Stage 6: output channels.
    logic [CW-1:0]           r_red;
    logic [CW-1:0]           r_green;
    logic [CW-1:0]           r_blue;

    // Busy covers the reset cycles and the cycle after, valid bits shift on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PD-2:0], start & ~r_busy};
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_vld[PD-1];

    // The coarse hue divided by the steps per turn, by reciprocal multiply.
    assign n_turn_prod = (HW + S1)'(i_hue[hsv2rgb_pkg::HUE_WIDTH-1:SH])
                       * (HW + S1)'(TURN_RECIP);

    always_ff @(posedge i_clk) begin
        r_h1  <= i_hue[hsv2rgb_pkg::HUE_WIDTH-1:SH];
        r_k1  <= n_turn_prod[HW+S1-1:S1];
        r_lo1 <= i_hue[SH-1:0];
        r_s1  <= i_saturation;
        r_v1  <= i_brightness;
    end

    // The hue wraps to one turn, then the sector is found by comparison.
    assign n_m_full = (HW + 7)'(r_h1)
                    - (HW + 7)'(r_k1) * (HW + 7)'(hsv2rgb_pkg::STEPS_TURN);
    assign n_m      = n_m_full[6:0];

    always_comb begin
        priority if (n_m >= 7'd75) begin
            n_sec  = hsv2rgb_pkg::SEC_MAG_RED;
            n_base = 7'd75;
        end else if (n_m >= 7'd60) begin
            n_sec  = hsv2rgb_pkg::SEC_BLU_MAG;
            n_base = 7'd60;
        end else if (n_m >= 7'd45) begin
            n_sec  = hsv2rgb_pkg::SEC_CYN_BLU;
            n_base = 7'd45;
        end else if (n_m >= 7'd30) begin
            n_sec  = hsv2rgb_pkg::SEC_GRN_CYN;
            n_base = 7'd30;
        end else if (n_m >= 7'd15) begin
            n_sec  = hsv2rgb_pkg::SEC_YEL_GRN;
            n_base = 7'd15;
        end else begin
            n_sec  = hsv2rgb_pkg::SEC_RED_YEL;
            n_base = 7'd0;
        end
    end

    assign n_r15 = 4'(n_m - n_base);

    always_ff @(posedge i_clk) begin
        r_sec2 <= n_sec;
        r_rem2 <= {n_r15, r_lo1};
        r_s2   <= r_s1;
        r_v2   <= r_v1;
    end

    // Saturation times the fraction and its complement; p numerator times 15.
    assign n_dr = SEC_SIZE - r_rem2;
    assign n_vs = (2 * CW)'(r_v2) * (2 * CW)'(8'(hsv2rgb_pkg::CHAN_MAX) - r_s2);

    always_ff @(posedge i_clk) begin
        r_sec3 <= r_sec2;
        r_xq3  <= (RW + 8)'(r_s2) * (RW + 8)'(r_rem2);
        r_xt3  <= (RW + 8)'(r_s2) * (RW + 8)'(n_dr);
        r_pn3  <= NW'({n_vs, 4'b0000}) - NW'(n_vs);
        r_v3   <= r_v2;
    end

    // Brightness times the remaining fractions; the low hue bits drop out of
    // the divisor, leaving the same divisor as for p.
    assign n_q_full = (RW + 16)'(r_v3) * (RW + 16)'(DEN - r_xq3);
    assign n_t_full = (RW + 16)'(r_v3) * (RW + 16)'(DEN - r_xt3);

    always_ff @(posedge i_clk) begin
        r_sec4 <= r_sec3;
        r_qn4  <= n_q_full[SH+NW-1:SH];
        r_tn4  <= n_t_full[SH+NW-1:SH];
        r_pn4  <= r_pn3;
        r_v4   <= r_v3;
    end

    // Truncating division by 255 * 15 through the exact reciprocal.
    assign n_p_prod = (NW + hsv2rgb_pkg::RECIP_WIDTH)'(r_pn4)
                    * (NW + hsv2rgb_pkg::RECIP_WIDTH)'(hsv2rgb_pkg::CHAN_RECIP);
    assign n_q_prod = (NW + hsv2rgb_pkg::RECIP_WIDTH)'(r_qn4)
                    * (NW + hsv2rgb_pkg::RECIP_WIDTH)'(hsv2rgb_pkg::CHAN_RECIP);
    assign n_t_prod = (NW + hsv2rgb_pkg::RECIP_WIDTH)'(r_tn4)
                    * (NW + hsv2rgb_pkg::RECIP_WIDTH)'(hsv2rgb_pkg::CHAN_RECIP);

    always_ff @(posedge i_clk) begin
        r_sec5 <= r_sec4;
        r_p5   <= n_p_prod[hsv2rgb_pkg::RECIP_SHIFT+CW-1:hsv2rgb_pkg::RECIP_SHIFT];
        r_q5   <= n_q_prod[hsv2rgb_pkg::RECIP_SHIFT+CW-1:hsv2rgb_pkg::RECIP_SHIFT];
        r_t5   <= n_t_prod[hsv2rgb_pkg::RECIP_SHIFT+CW-1:hsv2rgb_pkg::RECIP_SHIFT];
        r_v5   <= r_v4;
    end

    // The sector routes v, p, q and t to the three channels.
    always_ff @(posedge i_clk) begin
        unique case (r_sec5)
            hsv2rgb_pkg::SEC_RED_YEL: begin
                r_red <= r_v5; r_green <= r_t5; r_blue <= r_p5;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
                r_red <= r_q5; r_green <= r_v5; r_blue <= r_p5;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
                r_red <= r_p5; r_green <= r_v5; r_blue <= r_t5;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
                r_red <= r_p5; r_green <= r_q5; r_blue <= r_v5;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
                r_red <= r_t5; r_green <= r_p5; r_blue <= r_v5;
            end
            default: begin
                r_red <= r_v5; r_green <= r_p5; r_blue <= r_q5;
            end
        endcase
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // Every accepted word gives its result strobe after the pipeline depth.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PD o_strobe)
        else $error("accepted word gave no result strobe");

    // Zero saturation always comes out as grey.
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_saturation == 8'd0, PD)) |->
        (o_red == o_green && o_green == o_blue))
        else $error("zero saturation did not give grey");

    // No channel exceeds the brightness of its word.
    a_bright_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_red <= $past(i_brightness, PD)
                   && o_green <= $past(i_brightness, PD)
                   && o_blue <= $past(i_brightness, PD)))
        else $error("channel above brightness");

    // Full saturation in the red-yellow sector leaves no blue.
    a_no_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_saturation == 8'hFF && i_hue < HUE_SEC0_END, PD))
        |-> (o_blue == 8'd0))
        else $error("blue present in saturated red-yellow sector");

endmodule

// ===== bench/tb_hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the HSV to RGB converter core
// Sends pixel words through the start/busy handshake and checks every
// strobed colour word against a predictor kept in the bench. The predictor
// uses exact integer forms of the conversion. It covers a directed set of
// sector edges, hue wrap, grey and full-scale words, then three random phases
// with different sender gaps.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_FRAC_BITS = 6;
    localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
    localparam int unsigned TURN_SPAN = 360 << HUE_FRAC_BITS;
    localparam int unsigned RANDOM_WORDS = 200;
    localparam int unsigned MAX_REPORTS = 10;

    // One colour word as it leaves the block.
    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] red;
        logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] green;
        logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] blue;
    } t_rgb_word;

    // Holds the colours still owed by the block, oldest first, and counts errors.
    class rgb_scoreboard;
        t_rgb_word   owed_rgb[$];
        int unsigned n_errors;
        int unsigned n_checked;

        // Exact integer HSV to RGB conversion with truncation.
        function t_rgb_word predict_rgb(logic [hsv2rgb_pkg::HUE_WIDTH-1:0] hue,
                                        logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] sat,
                                        logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] val);
            longint unsigned      wrapped, frac, den, s, v, p, q, t;
            hsv2rgb_pkg::t_sector sec;
            t_rgb_word            rgb;
            wrapped = longint'(hue) % TURN_SPAN;
            sec     = hsv2rgb_pkg::t_sector'(wrapped / SECTOR_SPAN);
            frac    = wrapped % SECTOR_SPAN;
            den     = hsv2rgb_pkg::CHAN_MAX * SECTOR_SPAN;
            s       = sat;
            v       = val;
            if (s == 0) begin
                rgb = '{val, val, val};
                return rgb;
            end
            p = (v * (hsv2rgb_pkg::CHAN_MAX - s)) / hsv2rgb_pkg::CHAN_MAX;
            q = (v * (den - s * frac)) / den;
            t = (v * (den - s * (SECTOR_SPAN - frac))) / den;
            case (sec)
                hsv2rgb_pkg::SEC_RED_YEL: rgb = '{val, t[7:0], p[7:0]};
                hsv2rgb_pkg::SEC_YEL_GRN: rgb = '{q[7:0], val, p[7:0]};
                hsv2rgb_pkg::SEC_GRN_CYN: rgb = '{p[7:0], val, t[7:0]};
                hsv2rgb_pkg::SEC_CYN_BLU: rgb = '{p[7:0], q[7:0], val};
                hsv2rgb_pkg::SEC_BLU_MAG: rgb = '{t[7:0], p[7:0], val};
                default:                  rgb = '{val, p[7:0], q[7:0]};
            endcase
            return rgb;
        endfunction

        // An input word was taken: its colour is now owed.
        function void note_pixel(logic [hsv2rgb_pkg::HUE_WIDTH-1:0] hue,
                                 logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] sat,
                                 logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] val);
            owed_rgb.push_back(predict_rgb(hue, sat, val));
        endfunction

        // A strobed colour word: compare it with the oldest owed colour.
        function void check_pixel(t_rgb_word got);
            t_rgb_word want;
            n_checked++;
            if (owed_rgb.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("colour word %0d: strobe with no pixel outstanding, got %h %h %h",
                             n_checked, got.red, got.green, got.blue);
                return;
            end
            want = owed_rgb.pop_front();
            if (got.red !== want.red || got.green !== want.green
                || got.blue !== want.blue) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("colour word %0d: expected rgb %h %h %h, got %h %h %h",
                             n_checked, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int unsigned outstanding();
            return owed_rgb.size();
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [hsv2rgb_pkg::HUE_WIDTH-1:0]  i_hue;
    logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] i_saturation;
    logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] i_brightness;
    logic                               o_strobe;
    logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] o_red;
    logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] o_green;
    logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] o_blue;

    rgb_scoreboard sb = new();

    hsv_to_rgb_converter_core #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_strobe    (o_strobe),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    // Free-running 12 ns clock.
    always #6 i_clk = ~i_clk;

    // Note each taken word and check each strobed colour at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_pixel(i_hue, i_saturation, i_brightness);
        if (o_strobe === 1'b1)
            sb.check_pixel('{o_red, o_green, o_blue});
    end

    // Leave start low for a random number of cycles with noise on the fields.
    task automatic idle_gap(input int unsigned pct);
        while ($urandom_range(99) < pct) begin
            start        <= 1'b0;
            i_hue        <= hsv2rgb_pkg::HUE_WIDTH'($urandom());
            i_saturation <= hsv2rgb_pkg::CHAN_WIDTH'($urandom());
            i_brightness <= hsv2rgb_pkg::CHAN_WIDTH'($urandom());
            @(posedge i_clk);
        end
    endtask

    // Present one pixel word and hold it until the block takes it.
    task automatic send_pixel(input logic [hsv2rgb_pkg::HUE_WIDTH-1:0] hue,
                              input logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] sat,
                              input logic [hsv2rgb_pkg::CHAN_WIDTH-1:0] val,
                              input int unsigned pct);
        idle_gap(pct);
        start        <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending until every owed colour has come out.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Boundary sweep first, then random phases with sender gaps of 9, 76 and 0 percent.
    initial begin
        int unsigned  gap_pct[3];
        logic [14:0]  hue;
        logic [7:0]   sat;
        logic [7:0]   val;
        int           dir_hue[23];
        int           dir_sat[23];
        int           dir_val[23];

        gap_pct = '{9, 76, 0};
        // Sector edges, top of the turn, wrapped hues, grey and black words.
        dir_hue = '{0, 3839, 3840, 7679, 7680, 11519, 11520, 15360, 17000, 19200,
                    21000, 23039, 23040, 24960, 32767, 1920, 30000, 5000, 12345,
                    9000, 0, 16384, 8191};
        dir_sat = '{255, 255, 255, 200, 255, 255, 128, 255, 255, 255,
                    77, 255, 255, 200, 255, 0, 0, 255, 1,
                    254, 0, 170, 85};
        dir_val = '{255, 255, 255, 255, 128, 255, 200, 255, 100, 255,
                    255, 255, 255, 180, 255, 255, 77, 0, 255,
                    1, 0, 85, 170};

        start        <= 1'b0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        i_rst_n      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_hue[i])
            send_pixel(hsv2rgb_pkg::HUE_WIDTH'(dir_hue[i]),
                       hsv2rgb_pkg::CHAN_WIDTH'(dir_sat[i]),
                       hsv2rgb_pkg::CHAN_WIDTH'(dir_val[i]), gap_pct[0]);
        drain_pipeline();

        // Random words: mostly in the nominal turn, some wrapped, some on edges.
        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < RANDOM_WORDS; n++) begin
                case ($urandom_range(9))
                    0:       hue = 15'($urandom_range(32767, TURN_SPAN));
                    1:       hue = 15'($urandom_range(5) * SECTOR_SPAN
                                   + ($urandom_range(1) ? SECTOR_SPAN - 1 : 0));
                    default: hue = 15'($urandom_range(TURN_SPAN - 1));
                endcase
                if ($urandom_range(7) == 0)
                    sat = $urandom_range(1) ? 8'd0 : 8'd255;
                else
                    sat = 8'($urandom_range(255));
                if ($urandom_range(7) == 0)
                    val = $urandom_range(1) ? 8'd0 : 8'd255;
                else
                    val = 8'($urandom_range(255));
                send_pixel(hue, sat, val, gap_pct[ph]);
            end
            drain_pipeline();
        end

        repeat (hsv2rgb_pkg::PIPE_DEPTH + 4) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("hsv_to_rgb_converter_core: match");
        end else begin
            $display("hsv_to_rgb_converter_core: mismatch");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #2_000_000;
        $display("hsv_to_rgb_converter_core: mismatch");
        $finish;
    end

endmodule
